/* design/mlbc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mlbc_pkg;

  localparam int OUT_W = 10;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam logic [OUT_W-1:0] PRESENT_RST = 10'h3FE;

  typedef enum logic [1:0] {
    CMD_OFF   = 2'd0,
    CMD_ON    = 2'd1,
    CMD_BLINK = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_BLINK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  led_index;
    logic [1:0]  command;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;
    logic [31:0] now;
  } in_word_t;

  typedef struct packed {
    logic [OUT_W-1:0] led_levels;
    logic [OUT_W-1:0] changed_mask;
  } out_word_t;

  typedef struct packed {
    logic latch;
    logic do_set;
    logic do_pend;
    logic do_blink;
    logic load_out;
  } ctrl_t;

  typedef struct packed {
    logic is_tick;
    logic last_led;
  } status_t;

endpackage

`default_nettype wire

/* design/mlbc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlbc_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire mlbc_pkg::status_t status_i,
  output mlbc_pkg::ctrl_t      ctrl_o
);

  mlbc_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != mlbc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mlbc_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = mlbc_pkg::ST_EXEC;
      end
      mlbc_pkg::ST_EXEC: begin
        state_d = status_i.is_tick ? mlbc_pkg::ST_BLINK : mlbc_pkg::ST_DONE;
      end
      mlbc_pkg::ST_BLINK: begin
        if (status_i.last_led) state_d = mlbc_pkg::ST_DONE;
      end
      mlbc_pkg::ST_DONE: begin
        if (out_free) state_d = mlbc_pkg::ST_IDLE;
      end
      default: state_d = mlbc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      mlbc_pkg::ST_IDLE:  ctrl_o.latch    = in_valid_i;
      mlbc_pkg::ST_EXEC: begin
        ctrl_o.do_set  = !status_i.is_tick;
        ctrl_o.do_pend = status_i.is_tick;
      end
      mlbc_pkg::ST_BLINK: ctrl_o.do_blink = 1'b1;
      mlbc_pkg::ST_DONE:  ctrl_o.load_out = out_free;
      default: ctrl_o = '0;
    endcase
  end

  always_comb begin
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlbc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

/* design/mlbc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlbc_datapath #(
  parameter int NUM_LEDS = 10
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [mlbc_pkg::OUT_W-1:0]   cfg_wdata_i,
  input  wire mlbc_pkg::in_word_t           in_word_i,
  input  wire mlbc_pkg::ctrl_t              ctrl_i,
  output mlbc_pkg::status_t                 status_o,
  output mlbc_pkg::out_word_t               out_word_o
);

  localparam int IDX_W = $clog2(NUM_LEDS);

  mlbc_pkg::in_word_t  item_q;
  mlbc_pkg::out_word_t out_q;

  logic [mlbc_pkg::OUT_W-1:0] mask_q;
  logic [NUM_LEDS-1:0] present;
  logic [NUM_LEDS-1:0] pend_on_q, pend_on_d;
  logic [NUM_LEDS-1:0] pend_off_q, pend_off_d;
  logic [NUM_LEDS-1:0] blink_q, blink_d;
  logic [NUM_LEDS-1:0] phase_on_q, phase_on_d;
  logic [NUM_LEDS-1:0] level_q, level_d;
  logic [NUM_LEDS-1:0] changed_q, changed_d;
  logic [31:0] start_q [NUM_LEDS];
  logic [31:0] start_d [NUM_LEDS];
  logic [15:0] on_dur_q [NUM_LEDS];
  logic [15:0] on_dur_d [NUM_LEDS];
  logic [15:0] off_dur_q [NUM_LEDS];
  logic [15:0] off_dur_d [NUM_LEDS];
  logic [IDX_W-1:0] idx_q, idx_d;

  logic [NUM_LEDS+mlbc_pkg::OUT_W-1:0] mask_ext;
  logic [NUM_LEDS+mlbc_pkg::OUT_W-1:0] level_ext;
  logic [NUM_LEDS+mlbc_pkg::OUT_W-1:0] changed_ext;
  logic [31:0] elapsed;
  logic [31:0] dur;
  logic        fire;
  logic        bcast;

  assign mask_ext    = {{NUM_LEDS{1'b0}}, mask_q};
  assign present     = mask_ext[NUM_LEDS-1:0];
  assign level_ext   = {{mlbc_pkg::OUT_W{1'b0}}, level_q};
  assign changed_ext = {{mlbc_pkg::OUT_W{1'b0}}, changed_q};

  assign bcast = (32'(item_q.led_index) == NUM_LEDS);

  // shared elapsed-time compare for the blink pass
  assign elapsed = item_q.now - start_q[idx_q];
  assign dur     = phase_on_q[idx_q] ? {16'd0, on_dur_q[idx_q]} : {16'd0, off_dur_q[idx_q]};
  assign fire    = blink_q[idx_q] && present[idx_q] && (elapsed >= dur);

  assign status_o.is_tick  = (item_q.req_type == mlbc_pkg::REQ_TICK);
  assign status_o.last_led = (idx_q == IDX_W'(NUM_LEDS - 1));
  assign out_word_o        = out_q;

  always_comb begin
    pend_on_d  = pend_on_q;
    pend_off_d = pend_off_q;
    blink_d    = blink_q;
    phase_on_d = phase_on_q;
    level_d    = level_q;
    changed_d  = changed_q;
    start_d    = start_q;
    on_dur_d   = on_dur_q;
    off_dur_d  = off_dur_q;
    idx_d      = idx_q;

    if (ctrl_i.latch) begin
      changed_d = '0;
      idx_d     = '0;
    end

    if (ctrl_i.do_set) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (bcast || (32'(item_q.led_index) == i)) begin
          case (mlbc_pkg::cmd_e'(item_q.command))
            mlbc_pkg::CMD_OFF: begin
              pend_off_d[i] = 1'b1;
              blink_d[i]    = 1'b0;
            end
            mlbc_pkg::CMD_ON: begin
              pend_on_d[i] = 1'b1;
              blink_d[i]   = 1'b0;
            end
            mlbc_pkg::CMD_BLINK: begin
              if (present[i] && !blink_q[i]) begin
                blink_d[i]    = 1'b1;
                on_dur_d[i]   = item_q.on_time_ms;
                off_dur_d[i]  = item_q.off_time_ms;
                start_d[i]    = item_q.now;
                phase_on_d[i] = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
    end

    // off then on, so a double request ends on
    if (ctrl_i.do_pend) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (pend_on_q[i] || pend_off_q[i]) begin
          pend_on_d[i]  = 1'b0;
          pend_off_d[i] = 1'b0;
          if (present[i]) begin
            level_d[i]   = pend_on_q[i];
            changed_d[i] = 1'b1;
          end
        end
      end
    end

    if (ctrl_i.do_blink) begin
      if (fire) begin
        start_d[idx_q]    = item_q.now;
        phase_on_d[idx_q] = !phase_on_q[idx_q];
        level_d[idx_q]    = !phase_on_q[idx_q];
        changed_d[idx_q]  = 1'b1;
      end
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= mlbc_pkg::PRESENT_RST;
      pend_on_q  <= '0;
      pend_off_q <= '0;
      blink_q    <= '0;
      phase_on_q <= '0;
      level_q    <= '0;
      idx_q      <= '0;
    end else begin
      if (cfg_we_i) mask_q <= cfg_wdata_i;
      pend_on_q  <= pend_on_d;
      pend_off_q <= pend_off_d;
      blink_q    <= blink_d;
      phase_on_q <= phase_on_d;
      level_q    <= level_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) item_q <= in_word_i;
    changed_q <= changed_d;
    start_q   <= start_d;
    on_dur_q  <= on_dur_d;
    off_dur_q <= off_dur_d;
    if (ctrl_i.load_out) begin
      out_q.led_levels   <= level_ext[mlbc_pkg::OUT_W-1:0];
      out_q.changed_mask <= changed_ext[mlbc_pkg::OUT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* design/multi_led_blink_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

// LED blink controller for up to NUM_LEDS LEDs (levels and change bits of the first ten are
// reported). One word is worked on at a time: a set command goes through accept, execute and
// hand-off, and a tick adds a blink pass before hand-off that steps through the LEDs one per
// cycle over a single shared elapsed-time subtract and compare. The input is held off from the
// accepting edge until the hand-off is done. The result sits in an output register, so a new
// word is taken while the previous result is still stalled; a finished word waits in hand-off
// while that register is full and its result is stalled. The user must write the present mask
// through cfg_we_i only between words, unenforced by the block; it applies from the next word.

module multi_led_blink_controller #(
  parameter int NUM_LEDS = 10
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [mlbc_pkg::OUT_W-1:0] cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire mlbc_pkg::in_word_t         in_word_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output mlbc_pkg::out_word_t             out_word_o
);

  mlbc_pkg::ctrl_t   ctrl;
  mlbc_pkg::status_t status;

  mlbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  mlbc_datapath #(
    .NUM_LEDS (NUM_LEDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

/* design/mlbc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module mlbc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire mlbc_pkg::in_word_t  in_word_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire mlbc_pkg::out_word_t out_word_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("stalled result changed");

  // one word in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken again while busy");

  // a set command never reports a change
  a_set_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_word_i.req_type == mlbc_pkg::REQ_SET) && !out_valid_o
      |=> ##2 (out_valid_o && (out_word_o.changed_mask == '0)))
    else $error("set command result shows changed leds");

endmodule

bind multi_led_blink_controller mlbc_checker u_mlbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

/* sim/tb_multi_led_blink_controller.sv */
`timescale 1ns / 1ps

module tb_multi_led_blink_controller;

  localparam int NUM_LEDS = 10;
  localparam logic [3:0] BCAST_IDX = 4'd10;
  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i;
  logic [mlbc_pkg::OUT_W-1:0] cfg_wdata_i;
  logic in_valid_i;
  logic in_stall_o;
  mlbc_pkg::in_word_t in_word_i;
  logic out_valid_o;
  logic out_stall_i;
  mlbc_pkg::out_word_t out_word_o;

  // shadow copy of the controller state
  logic [mlbc_pkg::OUT_W-1:0] present_mask;
  logic [NUM_LEDS-1:0] want_on, want_off, blink_act, blink_on_phase, led_lvl;
  logic [31:0] phase_t0 [NUM_LEDS];
  logic [15:0] on_len [NUM_LEDS];
  logic [15:0] off_len [NUM_LEDS];

  mlbc_pkg::out_word_t pending_led_results[$];
  logic [31:0] tick_now;
  int mismatches;
  int cycle_cnt;
  bit tx_burst;
  bit rx_burst;
  int rx_hold;

  multi_led_blink_controller #(
    .NUM_LEDS(NUM_LEDS)
  ) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o(out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic apply_led_cmd(input int i, input mlbc_pkg::in_word_t w);
    case (w.command)
      mlbc_pkg::CMD_OFF: begin
        want_off[i] = 1'b1;
        blink_act[i] = 1'b0;
      end
      mlbc_pkg::CMD_ON: begin
        want_on[i] = 1'b1;
        blink_act[i] = 1'b0;
      end
      mlbc_pkg::CMD_BLINK: begin
        if (present_mask[i] && !blink_act[i]) begin
          blink_act[i] = 1'b1;
          on_len[i] = w.on_time_ms;
          off_len[i] = w.off_time_ms;
          phase_t0[i] = w.now;
          blink_on_phase[i] = 1'b1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic compute_led_result(input mlbc_pkg::in_word_t w,
                                    output mlbc_pkg::out_word_t r);
    logic [NUM_LEDS-1:0] changed;
    logic [31:0] elapsed;
    changed = '0;
    if (w.req_type == mlbc_pkg::REQ_SET) begin
      if (w.led_index == BCAST_IDX) begin
        for (int i = 0; i < NUM_LEDS; i++) apply_led_cmd(i, w);
      end else if (w.led_index < NUM_LEDS) begin
        apply_led_cmd(int'(w.led_index), w);
      end
    end else begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (want_off[i]) begin
          want_off[i] = 1'b0;
          if (present_mask[i]) begin
            led_lvl[i] = 1'b0;
            changed[i] = 1'b1;
          end
        end
      end
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (want_on[i]) begin
          want_on[i] = 1'b0;
          if (present_mask[i]) begin
            led_lvl[i] = 1'b1;
            changed[i] = 1'b1;
          end
        end
      end
      for (int i = 0; i < NUM_LEDS; i++) begin
        if (blink_act[i] && present_mask[i]) begin
          elapsed = w.now - phase_t0[i];
          if (blink_on_phase[i] ? (elapsed >= {16'd0, on_len[i]})
                                : (elapsed >= {16'd0, off_len[i]})) begin
            phase_t0[i] = w.now;
            blink_on_phase[i] = !blink_on_phase[i];
            led_lvl[i] = blink_on_phase[i];
            changed[i] = 1'b1;
          end
        end
      end
    end
    r.led_levels = led_lvl[mlbc_pkg::OUT_W-1:0];
    r.changed_mask = changed[mlbc_pkg::OUT_W-1:0];
  endtask

  function automatic mlbc_pkg::in_word_t mk_word(input logic req, input logic [3:0] idx,
                                                 input logic [1:0] cmd,
                                                 input logic [15:0] on_t,
                                                 input logic [15:0] off_t,
                                                 input logic [31:0] t_now);
    mlbc_pkg::in_word_t w;
    w.req_type = req;
    w.led_index = idx;
    w.command = cmd;
    w.on_time_ms = on_t;
    w.off_time_ms = off_t;
    w.now = t_now;
    return w;
  endfunction

  // mostly a monotonic clock with short blink times, sometimes anything at all
  function automatic mlbc_pkg::in_word_t rand_word();
    mlbc_pkg::in_word_t w;
    if ($urandom_range(0, 99) < 2) tick_now = $urandom();
    else tick_now = tick_now + $urandom_range(0, 5);
    w.req_type = ($urandom_range(0, 99) < 45) ? mlbc_pkg::REQ_TICK : mlbc_pkg::REQ_SET;
    w.led_index = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, NUM_LEDS));
    w.command = ($urandom_range(0, 19) == 0) ? CMD_BAD : 2'($urandom_range(0, 2));
    w.on_time_ms = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12));
    w.off_time_ms = ($urandom_range(0, 4) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 12));
    w.now = ($urandom_range(0, 19) == 0) ? 32'($urandom()) : tick_now;
    return w;
  endfunction

  task automatic send_word(input mlbc_pkg::in_word_t w);
    int gap;
    mlbc_pkg::out_word_t exp_w;
    gap = tx_burst ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    compute_led_result(w, exp_w);
    pending_led_results.push_back(exp_w);
  endtask

  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_led_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_present_mask(input logic [mlbc_pkg::OUT_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    present_mask = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_directed();
    send_word(mk_word(mlbc_pkg::REQ_TICK, 4'd0, mlbc_pkg::CMD_OFF, 16'd0, 16'd0, 32'd0));
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd1, mlbc_pkg::CMD_ON, 16'd0, 16'd0, 32'd0));
    // dummy entry is absent after reset
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd0, mlbc_pkg::CMD_ON, 16'd0, 16'd0, 32'd0));
    send_word(mk_word(mlbc_pkg::REQ_TICK, 4'd0, mlbc_pkg::CMD_OFF, 16'd0, 16'd0, 32'd1));
    // off then on before one tick
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd1, mlbc_pkg::CMD_OFF, 16'd0, 16'd0, 32'd1));
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd1, mlbc_pkg::CMD_ON, 16'd0, 16'd0, 32'd1));
    send_word(mk_word(mlbc_pkg::REQ_TICK, 4'd0, mlbc_pkg::CMD_OFF, 16'd0, 16'd0, 32'd2));
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd11, mlbc_pkg::CMD_ON, 16'd0, 16'd0, 32'd2));
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd15, mlbc_pkg::CMD_OFF, 16'd0, 16'd0, 32'd2));
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd2, CMD_BAD, 16'd3, 16'd3, 32'd2));
    send_word(mk_word(mlbc_pkg::REQ_TICK, 4'd0, mlbc_pkg::CMD_OFF, 16'd0, 16'd0, 32'd3));
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd0, mlbc_pkg::CMD_BLINK, 16'd1, 16'd1, 32'd3));
    // zero durations, then a refused second blink
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd3, mlbc_pkg::CMD_BLINK, 16'd0, 16'd0, 32'd5));
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd3, mlbc_pkg::CMD_BLINK, 16'd7, 16'd7, 32'd5));
    send_word(mk_word(mlbc_pkg::REQ_TICK, 4'd0, mlbc_pkg::CMD_OFF, 16'd0, 16'd0, 32'd5));
    send_word(mk_word(mlbc_pkg::REQ_TICK, 4'd0, mlbc_pkg::CMD_OFF, 16'd0, 16'd0, 32'd5));
    // elapsed time across the 32-bit wrap
    send_word(mk_word(mlbc_pkg::REQ_SET, 4'd4, mlbc_pkg::CMD_BLINK, 16'hFFFF, 16'hFFFF,
                      32'hFFFF_FFF0));
    send_word(mk_word(mlbc_pkg::REQ_TICK, 4'd0, mlbc_pkg::CMD_OFF, 16'd0, 16'd0,
                      32'h0000_FFEF));
    send_word(mk_word(mlbc_pkg::REQ_SET, BCAST_IDX, mlbc_pkg::CMD_OFF, 16'd0, 16'd0,
                      32'h0000_FFEF));
    send_word(mk_word(mlbc_pkg::REQ_TICK, 4'hF, CMD_BAD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_word(mk_word(mlbc_pkg::REQ_SET, BCAST_IDX, mlbc_pkg::CMD_BLINK, 16'd1, 16'd2,
                      32'hFFFF_FFFF));
    send_word(mk_word(mlbc_pkg::REQ_TICK, 4'd0, mlbc_pkg::CMD_OFF, 16'd0, 16'd0, 32'd0));
    send_word(mk_word(mlbc_pkg::REQ_SET, BCAST_IDX, mlbc_pkg::CMD_ON, 16'd0, 16'd0, 32'd0));
    send_word(mk_word(mlbc_pkg::REQ_TICK, 4'd0, mlbc_pkg::CMD_OFF, 16'd0, 16'd0, 32'd3));
    tick_now = 32'd3;
  endtask

  task automatic test_present_mask();
    logic [mlbc_pkg::OUT_W-1:0] masks [6];
    masks = '{10'h000, 10'h3FF, 10'($urandom()), 10'($urandom()), 10'($urandom()),
              mlbc_pkg::PRESENT_RST};
    foreach (masks[k]) begin
      drain_block();
      write_present_mask(masks[k]);
      repeat (100) send_word(rand_word());
    end
  endtask

  task automatic test_back_to_back();
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    repeat (200) send_word(rand_word());
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  task automatic test_backpressure();
    drain_block();
    rx_hold = 300;
    tx_burst = 1'b1;
    repeat (60) send_word(rand_word());
    tx_burst = 1'b0;
  endtask

  task automatic test_random_traffic();
    repeat (200) send_word(rand_word());
    drain_block();
    write_present_mask(10'($urandom()));
    repeat (200) send_word(rand_word());
  endtask

  initial begin : rx_side
    int n;
    @(posedge rst_ni);
    forever begin
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
      end else begin
        n = rx_burst ? 0 : $urandom_range(0, 13);
      end
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(negedge clk_i);
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o === 1'b1 && out_stall_i === 1'b0));
    end
  end

  always @(posedge clk_i) begin : check_words
    mlbc_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_led_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: levels %h changed %h",
                   out_word_o.led_levels, out_word_o.changed_mask);
      end else begin
        exp_w = pending_led_results.pop_front();
        if (out_word_o.led_levels !== exp_w.led_levels ||
            out_word_o.changed_mask !== exp_w.changed_mask) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: levels exp %h got %h, changed exp %h got %h",
                     exp_w.led_levels, out_word_o.led_levels,
                     exp_w.changed_mask, out_word_o.changed_mask);
        end
      end
    end
  end

  initial begin
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    out_stall_i = 1'b0;
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    rx_hold = 0;
    mismatches = 0;
    cycle_cnt = 0;
    tick_now = '0;
    present_mask = mlbc_pkg::PRESENT_RST;
    want_on = '0;
    want_off = '0;
    blink_act = '0;
    blink_on_phase = '0;
    led_lvl = '0;
    for (int i = 0; i < NUM_LEDS; i++) begin
      phase_t0[i] = '0;
      on_len[i] = '0;
      off_len[i] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_present_mask();
    test_back_to_back();
    test_backpressure();
    test_random_traffic();

    drain_block();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* multi_led_blink_controller.f */
design/mlbc_pkg.sv
design/mlbc_ctrl.sv
design/mlbc_datapath.sv
design/multi_led_blink_controller.sv
design/mlbc_checker.sv
sim/tb_multi_led_blink_controller.sv
